FILE: rtl/core/assert_macros.svh
// shared assertion macros, clk and rst come from the enclosing module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/tcrp_pkg.sv
package tcrp_pkg;

  localparam int COST_W = 20;
  localparam int IDX_W = 3;
  localparam int QUEUE_DEPTH_DEF = 4;

  // register indices
  localparam logic [IDX_W-1:0] REG_MODE = 3'd0;
  localparam logic [IDX_W-1:0] REG_CRATE = 3'd1;
  localparam logic [IDX_W-1:0] REG_PRATE = 3'd2;
  localparam logic [IDX_W-1:0] REG_CCAP = 3'd3;
  localparam logic [IDX_W-1:0] REG_PCAP = 3'd4;

  typedef enum logic [1:0] {
    MODE_TB  = 2'd0,
    MODE_SR  = 2'd1,
    MODE_TR  = 2'd2,
    MODE_OFF = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    COLOR_NONE   = 2'd0,
    COLOR_GREEN  = 2'd1,
    COLOR_YELLOW = 2'd2,
    COLOR_RED    = 2'd3
  } color_t;

  typedef struct packed {
    mode_t       mode;
    logic [31:0] crate;
    logic [31:0] prate;
    logic [31:0] ccap;
    logic [31:0] pcap;
  } cfg_t;

  typedef struct packed {
    logic        ccap_we;
    logic        pcap_we;
    logic [31:0] data;
  } cap_wr_t;

  typedef struct packed {
    mode_t             mode;
    logic [COST_W-1:0] cost;
    logic [31:0]       cprod;
    logic [31:0]       pprod;
  } item_t;

endpackage

FILE: rtl/core/tcrp_front.sv
module tcrp_front
  import tcrp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] now_time,
  input  logic [15:0] frame_length,
  input  logic [7:0]  header_length,
  input  logic        q_full,
  output logic        push,
  output item_t       push_item
);

  logic              s1_valid;
  mode_t             s1_mode;
  logic [31:0]       s1_ticks;
  logic [COST_W-1:0] s1_cost;
  logic              s2_valid;
  mode_t             s2_mode;
  logic [COST_W-1:0] s2_cost;
  logic [31:0]       s2_cprod;
  logic [31:0]       s2_pprod;
  logic [31:0]       last_time;
  logic              s1_en;
  logic              s2_en;
  logic              accept;
  logic [16:0]       len_sum;
  logic [63:0]       cprod_full;
  logic [63:0]       pprod_full;

  assign s2_en    = !s2_valid || !q_full;
  assign s1_en    = !s1_valid || s2_en;
  assign in_stall = !s1_en;
  assign accept   = in_valid && s1_en;
  assign len_sum  = {1'b0, frame_length} + {9'b0, header_length};

  // saturating credit products
  assign cprod_full = {32'b0, s1_ticks} * {32'b0, cfg.crate};
  assign pprod_full = {32'b0, s1_ticks} * {32'b0, cfg.prate};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      last_time <= '0;
    end else begin
      if (s1_en) begin
        s1_valid <= in_valid;
      end
      if (s2_en) begin
        s2_valid <= s1_valid;
      end
      if (accept && cfg.mode != MODE_OFF) begin
        last_time <= now_time;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mode  <= cfg.mode;
      s1_ticks <= now_time - last_time;
      s1_cost  <= {len_sum, 3'b000};
    end
    if (s2_en && s1_valid) begin
      s2_mode  <= s1_mode;
      s2_cost  <= s1_cost;
      s2_cprod <= (|cprod_full[63:32]) ? 32'hFFFF_FFFF : cprod_full[31:0];
      s2_pprod <= (|pprod_full[63:32]) ? 32'hFFFF_FFFF : pprod_full[31:0];
    end
  end

  assign push            = s2_valid && !q_full;
  assign push_item.mode  = s2_mode;
  assign push_item.cost  = s2_cost;
  assign push_item.cprod = s2_cprod;
  assign push_item.pprod = s2_pprod;

`include "assert_macros.svh"

  `CHK_NEXT(a_s2_hold, s2_valid && q_full, s2_valid && $stable(s2_cost), "front lost a blocked beat")

endmodule

FILE: rtl/core/tcrp_queue.sv
module tcrp_queue
  import tcrp_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output item_t head,
  output logic  full,
  output logic  empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  item_t         mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = count == FULL_CNT;
  assign empty = count == '0;
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

`include "assert_macros.svh"

  `CHK_IMPL(a_no_overflow, push, !full || pop, "push into full queue")
  `CHK_IMPL(a_no_underflow, pop, !empty, "pop from empty queue")

endmodule

FILE: rtl/core/tcrp_back.sv
module tcrp_back
  import tcrp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  cap_wr_t     cap_wr,
  input  item_t       head,
  input  logic        q_empty,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        matched,
  output logic [1:0]  color
);

  logic [31:0] cc;
  logic [31:0] pc;
  logic [31:0] cc_next;
  logic [31:0] pc_next;
  logic        matched_next;
  color_t      color_next;
  logic [32:0] csum;
  logic        c_over;
  logic [31:0] c_clamp;
  logic [32:0] c_extra;
  logic [32:0] p_term;
  logic [33:0] psum;
  logic [31:0] p_clamp;
  logic        p_upd;
  logic [31:0] p_avail;
  logic [31:0] cost32;
  color_t      color_q;

  assign pop    = !q_empty && (!out_valid || !out_stall);
  assign cost32 = {{(32 - COST_W){1'b0}}, head.cost};

  always_comb begin
    csum    = {1'b0, cc} + {1'b0, head.cprod};
    c_over  = csum > {1'b0, cfg.ccap};
    c_clamp = c_over ? cfg.ccap : csum[31:0];
    c_extra = csum - {1'b0, cfg.ccap};
    // excess overflow feeds peak in single-rate, peak rate in two-rate
    p_term  = (head.mode == MODE_TR) ? {1'b0, head.pprod} : c_extra;
    psum    = {2'b0, pc} + {1'b0, p_term};
    p_clamp = (psum > {2'b0, cfg.pcap}) ? cfg.pcap : psum[31:0];
    p_upd   = (head.mode == MODE_TR) || (c_over && (pc < cfg.pcap));
    p_avail = p_upd ? p_clamp : pc;

    cc_next      = cc;
    pc_next      = pc;
    matched_next = 1'b0;
    color_next   = COLOR_NONE;
    case (head.mode)
      MODE_TB: begin
        cc_next = c_clamp;
        if (c_clamp >= cost32) begin
          cc_next      = c_clamp - cost32;
          matched_next = 1'b1;
        end
      end
      MODE_SR: begin
        cc_next      = c_clamp;
        pc_next      = p_avail;
        matched_next = 1'b1;
        if (c_clamp >= cost32) begin
          cc_next    = c_clamp - cost32;
          color_next = COLOR_GREEN;
        end else if (p_avail >= cost32) begin
          pc_next    = p_avail - cost32;
          color_next = COLOR_YELLOW;
        end else begin
          color_next = COLOR_RED;
        end
      end
      MODE_TR: begin
        cc_next      = c_clamp;
        pc_next      = p_avail;
        matched_next = 1'b1;
        if (p_avail < cost32) begin
          color_next = COLOR_RED;
        end else if (c_clamp < cost32) begin
          pc_next    = p_avail - cost32;
          color_next = COLOR_YELLOW;
        end else begin
          pc_next    = p_avail - cost32;
          cc_next    = c_clamp - cost32;
          color_next = COLOR_GREEN;
        end
      end
      default: begin
        cc_next = cc;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cc        <= '0;
      pc        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cap_wr.ccap_we) begin
        cc <= cap_wr.data;
      end else if (pop) begin
        cc <= cc_next;
      end
      if (cap_wr.pcap_we) begin
        pc <= cap_wr.data;
      end else if (pop) begin
        pc <= pc_next;
      end
      if (pop) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      matched <= matched_next;
      color_q <= color_next;
    end
  end

  assign color = color_q;

`include "assert_macros.svh"

  `CHK_IMPL(a_cc_capped, 1'b1, cc <= cfg.ccap, "committed credit above cap")
  `CHK_IMPL(a_pc_capped, 1'b1, pc <= cfg.pcap, "peak credit above cap")

endmodule

FILE: rtl/core/three_color_rate_policer.sv
// channel  | direction | handshake          | payload
// ---------+-----------+--------------------+-----------------------------------------
// in       | to block  | in_valid/in_stall   | now_time, frame_length, header_length
// out      | from block| out_valid/out_stall | matched, color
// cfg      | to block  | cfg_write           | cfg_index, cfg_data
//
// one beat accepted per cycle while in_stall is low, one result per beat
// from input beat to result the path runs:
//   tick difference, then the two rate products, then the queue, then the bucket update
// the credit recurrence closes in the back part, one add/clamp/compare chain per beat
// reset is synchronous and clears modes, rates, caps, credits and the timestamp
// a stall on the output fills the queue first; the input stalls only once it is full
module three_color_rate_policer
  import tcrp_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  // configuration write port
  input  logic             cfg_write,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [31:0]      cfg_data,
  // packet arrivals
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [31:0]      now_time,
  input  logic [15:0]      frame_length,
  input  logic [7:0]       header_length,
  // marking results
  output logic             out_valid,
  input  logic             out_stall,
  output logic             matched,
  output logic [1:0]       color
);

  cfg_t    cfg;
  cap_wr_t cap_wr;
  item_t   push_item;
  item_t   head;
  logic    push;
  logic    pop;
  logic    q_full;
  logic    q_empty;

  // register file; the user must write it only while the block is idle, the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MODE:  cfg.mode  <= mode_t'(cfg_data[1:0]);
        REG_CRATE: cfg.crate <= cfg_data;
        REG_PRATE: cfg.prate <= cfg_data;
        REG_CCAP:  cfg.ccap  <= cfg_data;
        REG_PCAP:  cfg.pcap  <= cfg_data;
        default: begin
          cfg <= cfg;
        end
      endcase
    end
  end

  // a cap write also refills its bucket
  assign cap_wr.ccap_we = cfg_write && (cfg_index == REG_CCAP);
  assign cap_wr.pcap_we = cfg_write && (cfg_index == REG_PCAP);
  assign cap_wr.data    = cfg_data;

  // front: timestamp delta, cost and saturated credit products
  tcrp_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .now_time      (now_time),
    .frame_length  (frame_length),
    .header_length (header_length),
    .q_full        (q_full),
    .push          (push),
    .push_item     (push_item)
  );

  // decoupling queue between classification and bucket update
  tcrp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  // back: bucket credits, marking and output register
  tcrp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cap_wr    (cap_wr),
    .head      (head),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .matched   (matched),
    .color     (color)
  );

endmodule
